// ===== design/dpda_pkg.sv =====
// package for the pushdown automaton recognizer: codes, state encoding, defaults
// no dependencies
package dpda_pkg;

  localparam int TABLE_DEPTH_DEF     = 32;
  localparam int STACK_DEPTH_DEF     = 64;
  localparam int STATE_BITS_DEF      = 4;
  localparam int SYMBOL_BITS_DEF     = 4;
  localparam int MAX_EMPTY_MOVES_DEF = 16;

  localparam int ENTRY_IDX_W = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 6;
  localparam int TE_W        = 6;
  localparam int STATUS_W    = 3;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_BEGIN  = 2'd1,
    CMD_SYMBOL = 2'd2,
    CMD_END    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_STUCK    = 3'd1,
    ST_ACCEPT   = 3'd2,
    ST_REJECT   = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_ENTRIES   = 3'd0,
    CFG_START_STATE     = 3'd1,
    CFG_FINAL_STATE_A   = 3'd2,
    CFG_FINAL_STATE_B   = 3'd3,
    CFG_BOTTOM_REQUIRED = 3'd4,
    CFG_BOTTOM_SYMBOL   = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY,
    S_REFILL,
    S_NEXT,
    S_CHEND,
    S_DONE
  } fsm_e;

endpackage

// ===== design/dpda_in_if.sv =====
// input channel of the recognizer: valid/ready plus command and table entry fields
// no dependencies
interface dpda_in_if #(
  parameter int STATE_BITS  = 4,
  parameter int SYMBOL_BITS = 4,
  parameter int IDX_W       = 5
) ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             command;
  logic [IDX_W-1:0]       entry_index;
  logic [STATE_BITS-1:0]  from_state;
  logic                   read_is_empty;
  logic [SYMBOL_BITS-1:0] read_symbol;
  logic                   pop_is_empty;
  logic [SYMBOL_BITS-1:0] pop_symbol;
  logic [STATE_BITS-1:0]  to_state;
  logic                   push_is_empty;
  logic [SYMBOL_BITS-1:0] push_symbol;
  logic [SYMBOL_BITS-1:0] input_symbol;

  modport source (
    output valid, command, entry_index, from_state, read_is_empty, read_symbol,
           pop_is_empty, pop_symbol, to_state, push_is_empty, push_symbol, input_symbol,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, from_state, read_is_empty, read_symbol,
           pop_is_empty, pop_symbol, to_state, push_is_empty, push_symbol, input_symbol,
    output ready
  );
endinterface

// ===== design/dpda_out_if.sv =====
// result channel of the recognizer: valid/ready plus status and stack view
// no dependencies
interface dpda_out_if #(
  parameter int STATE_BITS  = 4,
  parameter int SYMBOL_BITS = 4,
  parameter int SP_W        = 7,
  parameter int STAT_W      = 3
) ();
  logic                   valid;
  logic                   ready;
  logic [STAT_W-1:0]      status;
  logic [STATE_BITS-1:0]  current_state;
  logic [SP_W-1:0]        stack_depth;
  logic [SYMBOL_BITS-1:0] top_symbol;

  modport source (output valid, status, current_state, stack_depth, top_symbol, input ready);
  modport sink   (input  valid, status, current_state, stack_depth, top_symbol, output ready);
endinterface

// ===== design/dpda_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module dpda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== design/dpda_recognizer_unit.sv =====
// top level of the deterministic pushdown automaton recognizer
// depends on dpda_pkg, dpda_in_if, dpda_out_if and dpda_ram
//
// One input transaction in, one result transaction out. Write-entry and begin-string
// transactions go straight from idle to the done state. An input symbol or end string
// runs a chain of up to MAX_EMPTY_MOVES empty-read moves, then one read move (symbol)
// or the accept test (end). Each search walks the transition table ram one entry a
// cycle, up to table_entries entries, and a taken move passes through the apply and
// next states, with a refill state between them when a pop with no push must refetch
// the new top from the stack ram. The table ram and the stack ram are not cleared;
// there is no clearing pass.
// The result sits in an output register, so a new transaction is taken while a
// result waits.
module dpda_recognizer_unit
  import dpda_pkg::*;
#(
  parameter int TABLE_DEPTH     = TABLE_DEPTH_DEF,
  parameter int STACK_DEPTH     = STACK_DEPTH_DEF,
  parameter int STATE_BITS      = STATE_BITS_DEF,
  parameter int SYMBOL_BITS     = SYMBOL_BITS_DEF,
  parameter int MAX_EMPTY_MOVES = MAX_EMPTY_MOVES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dpda_in_if.sink               in_i,
  dpda_out_if.source            out_o
);
  localparam int TAW     = $clog2(TABLE_DEPTH);
  localparam int PW      = $clog2(TABLE_DEPTH + 1);
  localparam int SAW     = $clog2(STACK_DEPTH);
  localparam int SP_W    = $clog2(STACK_DEPTH + 1);
  localparam int MV_W    = $clog2(MAX_EMPTY_MOVES + 1);
  localparam int ENTRY_W = 2 * STATE_BITS + 3 * SYMBOL_BITS + 3;

  // configuration registers
  logic [TE_W-1:0]        te_q;
  logic [STATE_BITS-1:0]  start_q, fin_a_q, fin_b_q;
  logic                   bot_req_q;
  logic [SYMBOL_BITS-1:0] bot_sym_q;
  logic [31:0]            cfg_wide;

  assign cfg_wide = 32'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      te_q      <= '0;
      start_q   <= '0;
      fin_a_q   <= '0;
      fin_b_q   <= '0;
      bot_req_q <= 1'b1;
      bot_sym_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TABLE_ENTRIES:   te_q      <= cfg_wide[TE_W-1:0];
        CFG_START_STATE:     start_q   <= cfg_wide[STATE_BITS-1:0];
        CFG_FINAL_STATE_A:   fin_a_q   <= cfg_wide[STATE_BITS-1:0];
        CFG_FINAL_STATE_B:   fin_b_q   <= cfg_wide[STATE_BITS-1:0];
        CFG_BOTTOM_REQUIRED: bot_req_q <= cfg_wide[0];
        CFG_BOTTOM_SYMBOL:   bot_sym_q <= cfg_wide[SYMBOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // number of entries searched, saturated at the table depth
  logic [PW-1:0] n_ent;
  assign n_ent = (32'(te_q) > TABLE_DEPTH) ? PW'(TABLE_DEPTH) : PW'(te_q);

  // control and automaton state
  fsm_e                   state_q, state_d;
  cmd_e                   cmd_q, cmd_d;
  logic                   want_empty_q, want_empty_d;
  logic [MV_W-1:0]        moves_q, moves_d;
  logic [PW-1:0]          ptr_q, ptr_d;
  logic                   rvalid_q, rvalid_d;
  logic [SYMBOL_BITS-1:0] sym_q, sym_d;
  logic [ENTRY_W-1:0]     ent_q, ent_d;
  logic [STATE_BITS-1:0]  ast_q, ast_d;
  logic [SP_W-1:0]        sp_q, sp_d;
  logic [SYMBOL_BITS-1:0] top_q, top_d;
  logic                   stuck_q, stuck_d;
  status_e                status_q, status_d;

  // output register
  logic                   ov_q, ov_d;
  status_e                o_stat_q, o_stat_d;
  logic [STATE_BITS-1:0]  o_st_q, o_st_d;
  logic [SP_W-1:0]        o_sp_q, o_sp_d;
  logic [SYMBOL_BITS-1:0] o_top_q, o_top_d;

  // memory ports
  logic                   tbl_we;
  logic [TAW-1:0]         tbl_waddr, tbl_raddr;
  logic [ENTRY_W-1:0]     tbl_wdata, tbl_rdata;
  logic                   stk_we;
  logic [SAW-1:0]         stk_waddr, stk_raddr;
  logic [SYMBOL_BITS-1:0] stk_wdata, stk_rdata;

  dpda_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  dpda_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // entry fields of the word coming out of the table ram
  logic [STATE_BITS-1:0]  r_from, r_to;
  logic                   r_rde, r_pope, r_pushe;
  logic [SYMBOL_BITS-1:0] r_rds, r_pops, r_pushs;
  assign {r_from, r_rde, r_rds, r_pope, r_pops, r_to, r_pushe, r_pushs} = tbl_rdata;

  // fields of the move being applied
  logic [STATE_BITS-1:0]  e_from, e_to;
  logic                   e_rde, e_pope, e_pushe;
  logic [SYMBOL_BITS-1:0] e_rds, e_pops, e_pushs;
  assign {e_from, e_rde, e_rds, e_pope, e_pops, e_to, e_pushe, e_pushs} = ent_q;

  // match test on the entry read in the previous cycle
  logic hit;
  assign hit = rvalid_q && (r_from == ast_q)
            && (want_empty_q ? r_rde : (!r_rde && (r_rds == sym_q)))
            && (r_pope || ((sp_q != '0) && (top_q == r_pops)));

  // stack pointer after the pop part of the move
  logic [SP_W-1:0] sp_pop;
  assign sp_pop = !e_pope ? sp_q - SP_W'(1) : sp_q;

  // accept test at end of string
  logic fin_ok, stk_ok;
  assign fin_ok = (ast_q == fin_a_q) || (ast_q == fin_b_q);
  assign stk_ok = bot_req_q ? ((sp_q != '0) && (top_q == bot_sym_q)) : (sp_q == '0);

  logic out_free;
  assign out_free = !ov_q || out_o.ready;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    want_empty_d = want_empty_q;
    moves_d      = moves_q;
    ptr_d        = ptr_q;
    rvalid_d     = 1'b0;
    sym_d        = sym_q;
    ent_d        = ent_q;
    ast_d        = ast_q;
    sp_d         = sp_q;
    top_d        = top_q;
    stuck_d      = stuck_q;
    status_d     = status_q;
    ov_d         = ov_q && !out_o.ready;
    o_stat_d     = o_stat_q;
    o_st_d       = o_st_q;
    o_sp_d       = o_sp_q;
    o_top_d      = o_top_q;
    tbl_we       = 1'b0;
    tbl_waddr    = TAW'(in_i.entry_index);
    tbl_wdata    = {in_i.from_state, in_i.read_is_empty, in_i.read_symbol,
                    in_i.pop_is_empty, in_i.pop_symbol, in_i.to_state,
                    in_i.push_is_empty, in_i.push_symbol};
    tbl_raddr    = ptr_q[TAW-1:0];
    stk_we       = 1'b0;
    stk_waddr    = sp_pop[SAW-1:0];
    stk_wdata    = e_pushs;
    stk_raddr    = SAW'(sp_pop - SP_W'(1));
    in_i.ready   = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d    = cmd_e'(in_i.command);
          sym_d    = in_i.input_symbol;
          status_d = ST_OK;
          state_d  = S_DONE;
          case (cmd_e'(in_i.command))
            CMD_WRITE: begin
              tbl_we = (32'(in_i.entry_index) < TABLE_DEPTH);
            end
            CMD_BEGIN: begin
              ast_d   = start_q;
              sp_d    = '0;
              stuck_d = 1'b0;
            end
            CMD_SYMBOL, CMD_END: begin
              if (stuck_q) begin
                status_d = (cmd_e'(in_i.command) == CMD_END) ? ST_REJECT : ST_STUCK;
              end else begin
                // empty-read chain comes first
                want_empty_d = 1'b1;
                moves_d      = '0;
                ptr_d        = '0;
                state_d      = S_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end

      // one table entry read per cycle, checked in the cycle after its read
      S_SEARCH: begin
        if (hit) begin
          ent_d   = tbl_rdata;
          state_d = S_APPLY;
        end else if (ptr_q >= n_ent) begin
          if (want_empty_q) begin
            state_d = S_CHEND;
          end else begin
            stuck_d  = 1'b1;
            status_d = ST_STUCK;
            state_d  = S_DONE;
          end
        end else begin
          ptr_d    = ptr_q + PW'(1);
          rvalid_d = 1'b1;
        end
      end

      S_APPLY: begin
        ast_d = e_to;
        if (want_empty_q) begin
          moves_d = moves_q + MV_W'(1);
        end
        if (!e_pushe) begin
          if (sp_pop == SP_W'(STACK_DEPTH)) begin
            // push dropped on a full stack
            sp_d     = sp_pop;
            stuck_d  = 1'b1;
            status_d = ST_OVERFLOW;
            state_d  = S_DONE;
          end else begin
            stk_we  = 1'b1;
            sp_d    = sp_pop + SP_W'(1);
            top_d   = e_pushs;
            state_d = S_NEXT;
          end
        end else begin
          sp_d = sp_pop;
          // pop without push exposes an older symbol: refetch it
          state_d = (!e_pope && (sp_pop != '0)) ? S_REFILL : S_NEXT;
        end
      end

      S_REFILL: begin
        top_d   = stk_rdata;
        state_d = S_NEXT;
      end

      S_NEXT: begin
        if (!want_empty_q) begin
          status_d = ST_OK;
          state_d  = S_DONE;
        end else if (moves_q == MV_W'(MAX_EMPTY_MOVES)) begin
          state_d = S_CHEND;
        end else begin
          ptr_d   = '0;
          state_d = S_SEARCH;
        end
      end

      // empty-read chain finished
      S_CHEND: begin
        if (cmd_q == CMD_END) begin
          status_d = (fin_ok && stk_ok) ? ST_ACCEPT : ST_REJECT;
          state_d  = S_DONE;
        end else begin
          want_empty_d = 1'b0;
          ptr_d        = '0;
          state_d      = S_SEARCH;
        end
      end

      S_DONE: begin
        if (out_free) begin
          ov_d     = 1'b1;
          o_stat_d = status_q;
          o_st_d   = ast_q;
          o_sp_d   = sp_q;
          o_top_d  = (sp_q != '0) ? top_q : '0;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= CMD_WRITE;
      want_empty_q <= 1'b0;
      moves_q      <= '0;
      ptr_q        <= '0;
      rvalid_q     <= 1'b0;
      ast_q        <= '0;
      sp_q         <= '0;
      stuck_q      <= 1'b0;
      status_q     <= ST_OK;
      ov_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      want_empty_q <= want_empty_d;
      moves_q      <= moves_d;
      ptr_q        <= ptr_d;
      rvalid_q     <= rvalid_d;
      ast_q        <= ast_d;
      sp_q         <= sp_d;
      stuck_q      <= stuck_d;
      status_q     <= status_d;
      ov_q         <= ov_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    sym_q    <= sym_d;
    ent_q    <= ent_d;
    top_q    <= top_d;
    o_stat_q <= o_stat_d;
    o_st_q   <= o_st_d;
    o_sp_q   <= o_sp_d;
    o_top_q  <= o_top_d;
  end

  assign out_o.valid         = ov_q;
  assign out_o.status        = o_stat_q;
  assign out_o.current_state = o_st_q;
  assign out_o.stack_depth   = o_sp_q;
  assign out_o.top_symbol    = o_top_q;

  // stack pointer never passes the stack depth
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  // a popping move was only matched with a non-empty stack
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY && !e_pope) |-> (sp_q != '0))
    else $error("pop applied on empty stack");

  // the empty-move chain respects its cap
  a_moves_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    moves_q <= MV_W'(MAX_EMPTY_MOVES))
    else $error("empty move chain over cap");

  // an overflow result always leaves the string stuck
  a_ovf_stuck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q == ST_OVERFLOW) |-> stuck_q)
    else $error("overflow without stuck mark");

endmodule

// ===== tb/tb_dpda_recognizer_unit.sv =====
// self-checking testbench for dpda_recognizer_unit: directed and random transactions
// depends on dpda_pkg, dpda_in_if, dpda_out_if and the recognizer rtl
module tb_dpda_recognizer_unit;
  import dpda_pkg::*;

  localparam int NUM_ENTRIES = 32;
  localparam int STACK_SLOTS = 64;
  localparam int CHAIN_CAP   = 16;
  localparam int CYCLE_LIMIT = 10000000;

  // one input transaction
  typedef struct {
    cmd_e       command;
    logic [4:0] entry_index;
    logic [3:0] from_state;
    logic       read_is_empty;
    logic [3:0] read_symbol;
    logic       pop_is_empty;
    logic [3:0] pop_symbol;
    logic [3:0] to_state;
    logic       push_is_empty;
    logic [3:0] push_symbol;
    logic [3:0] input_symbol;
  } dpda_item_t;

  // one result transaction
  typedef struct {
    status_e    status;
    logic [3:0] current_state;
    logic [6:0] stack_depth;
    logic [3:0] top_symbol;
  } dpda_result_t;

  // table entry as the automaton sees it
  typedef struct {
    logic [3:0] from_st;
    logic       rd_empty;
    logic [3:0] rd_sym;
    logic       pop_empty;
    logic [3:0] pop_sym;
    logic [3:0] to_st;
    logic       push_empty;
    logic [3:0] push_sym;
  } move_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dpda_in_if  in_bus ();
  dpda_out_if out_bus ();

  dpda_recognizer_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  // mirror of the automaton: table, stack, state and registers
  move_t      moves [NUM_ENTRIES];
  logic [3:0] sym_stack [STACK_SLOTS];
  int         sp;
  logic [3:0] cur_state;
  bit         stuck;
  int         n_entries;
  logic [3:0] start_st, final_a, final_b, bottom_sym;
  bit         need_bottom;

  dpda_result_t pending_results [$];
  int errors;
  int cycles;
  int items_sent;
  int send_idle_pct;
  int recv_idle_pct;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --- predictor ---------------------------------------------------------

  // an entry fits when state, read part and pop part all agree
  function automatic bit move_fits(int i, bit want_empty, logic [3:0] sym);
    if (moves[i].from_st != cur_state) return 1'b0;
    if (want_empty) begin
      if (!moves[i].rd_empty) return 1'b0;
    end else begin
      if (moves[i].rd_empty || moves[i].rd_sym != sym) return 1'b0;
    end
    if (moves[i].pop_empty) return 1'b1;
    return sp > 0 && sym_stack[sp-1] == moves[i].pop_sym;
  endfunction

  function automatic int first_move(bit want_empty, logic [3:0] sym);
    int lim;
    lim = n_entries > NUM_ENTRIES ? NUM_ENTRIES : n_entries;
    for (int i = 0; i < lim; i++)
      if (move_fits(i, want_empty, sym)) return i;
    return -1;
  endfunction

  // returns 1 when the push hits a full stack
  function automatic bit take_move(int i);
    if (!moves[i].pop_empty && sp > 0) sp--;
    cur_state = moves[i].to_st;
    if (!moves[i].push_empty) begin
      if (sp >= STACK_SLOTS) return 1'b1;
      sym_stack[sp] = moves[i].push_sym;
      sp++;
    end
    return 1'b0;
  endfunction

  function automatic bit run_empty_moves();
    int i;
    for (int k = 0; k < CHAIN_CAP; k++) begin
      i = first_move(1'b1, 4'd0);
      if (i < 0) break;
      if (take_move(i)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic dpda_result_t predict_step(dpda_item_t it);
    dpda_result_t r;
    int i;
    bit at_final, stack_good;
    r.status = ST_OK;
    case (it.command)
      CMD_WRITE: begin
        moves[it.entry_index] = '{it.from_state, it.read_is_empty, it.read_symbol,
                                  it.pop_is_empty, it.pop_symbol, it.to_state,
                                  it.push_is_empty, it.push_symbol};
      end
      CMD_BEGIN: begin
        cur_state = start_st;
        sp = 0;
        stuck = 1'b0;
      end
      CMD_SYMBOL: begin
        if (stuck) r.status = ST_STUCK;
        else if (run_empty_moves()) begin
          stuck = 1'b1;
          r.status = ST_OVERFLOW;
        end else begin
          i = first_move(1'b0, it.input_symbol);
          if (i < 0) begin
            stuck = 1'b1;
            r.status = ST_STUCK;
          end else if (take_move(i)) begin
            stuck = 1'b1;
            r.status = ST_OVERFLOW;
          end
        end
      end
      default: begin
        if (stuck) r.status = ST_REJECT;
        else if (run_empty_moves()) begin
          stuck = 1'b1;
          r.status = ST_OVERFLOW;
        end else begin
          at_final = cur_state == final_a || cur_state == final_b;
          if (need_bottom) stack_good = sp > 0 && sym_stack[sp-1] == bottom_sym;
          else stack_good = sp == 0;
          r.status = (at_final && stack_good) ? ST_ACCEPT : ST_REJECT;
        end
      end
    endcase
    r.current_state = cur_state;
    r.stack_depth   = 7'(sp);
    r.top_symbol    = sp > 0 ? sym_stack[sp-1] : 4'd0;
    return r;
  endfunction

  // --- result checker ----------------------------------------------------

  always @(posedge clk_i) begin
    dpda_result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d state %0d depth %0d top %0d",
                   out_bus.status, out_bus.current_state, out_bus.stack_depth,
                   out_bus.top_symbol);
      end else begin
        want = pending_results.pop_front();
        if (out_bus.status !== want.status || out_bus.current_state !== want.current_state ||
            out_bus.stack_depth !== want.stack_depth ||
            out_bus.top_symbol !== want.top_symbol) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     want.status, want.current_state, want.stack_depth, want.top_symbol,
                     out_bus.status, out_bus.current_state, out_bus.stack_depth,
                     out_bus.top_symbol);
        end
      end
    end
  end

  // receiver backpressure
  always @(negedge clk_i)
    out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

  // --- driving tasks -----------------------------------------------------

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_item(dpda_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid         <= 1'b1;
    in_bus.command       <= it.command;
    in_bus.entry_index   <= it.entry_index;
    in_bus.from_state    <= it.from_state;
    in_bus.read_is_empty <= it.read_is_empty;
    in_bus.read_symbol   <= it.read_symbol;
    in_bus.pop_is_empty  <= it.pop_is_empty;
    in_bus.pop_symbol    <= it.pop_symbol;
    in_bus.to_state      <= it.to_state;
    in_bus.push_is_empty <= it.push_is_empty;
    in_bus.push_symbol   <= it.push_symbol;
    in_bus.input_symbol  <= it.input_symbol;
    do @(posedge clk_i); while (!in_bus.ready);
    pending_results = {pending_results, predict_step(it)};
    items_sent++;
    @(negedge clk_i);
  endtask

  // wait until every result has arrived, then let the block settle
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // register write; only while idle
  task automatic write_reg(cfg_idx_e idx, int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TABLE_ENTRIES:   n_entries   = value & 6'h3f;
      CFG_START_STATE:     start_st    = 4'(value);
      CFG_FINAL_STATE_A:   final_a     = 4'(value);
      CFG_FINAL_STATE_B:   final_b     = 4'(value);
      CFG_BOTTOM_REQUIRED: need_bottom = value[0];
      default:             bottom_sym  = 4'(value);
    endcase
  endtask

  function automatic dpda_item_t make_cmd(cmd_e c, logic [3:0] sym);
    dpda_item_t it;
    it = '{c, 5'($urandom), 4'($urandom), 1'($urandom), 4'($urandom), 1'($urandom),
           4'($urandom), 4'($urandom), 1'($urandom), 4'($urandom), sym};
    return it;
  endfunction

  function automatic dpda_item_t make_entry(int idx, int fs, bit re, int rs, bit pe, int ps,
                                            int ts, bit he, int hs);
    dpda_item_t it;
    it = make_cmd(CMD_WRITE, 4'($urandom));
    it.entry_index = 5'(idx);
    it.from_state = 4'(fs); it.read_is_empty = re; it.read_symbol = 4'(rs);
    it.pop_is_empty = pe; it.pop_symbol = 4'(ps); it.to_state = 4'(ts);
    it.push_is_empty = he; it.push_symbol = 4'(hs);
    return it;
  endfunction

  // random entry biased toward few states and symbols so moves actually chain
  function automatic dpda_item_t rand_entry(int idx);
    if ($urandom_range(9) == 0)
      return make_entry(idx, $urandom, 1'($urandom), $urandom, 1'($urandom), $urandom,
                        $urandom, 1'($urandom), $urandom);
    return make_entry(idx, $urandom_range(3), $urandom_range(9) < 2, $urandom_range(3),
                      1'($urandom_range(1)), $urandom_range(3), $urandom_range(3),
                      $urandom_range(9) < 4, $urandom_range(3));
  endfunction

  // --- tests -------------------------------------------------------------

  // balanced brackets over a bottom marker: 0 opens, 1 closes
  task automatic test_directed_brackets();
    send_item(make_entry(0, 0, 1, 0, 1, 0, 1, 0, 15)); // push marker, enter state 1
    send_item(make_entry(1, 1, 0, 0, 1, 0, 1, 0, 1));  // open: push 1
    send_item(make_entry(2, 1, 0, 1, 0, 1, 1, 1, 0));  // close: pop 1
    send_item(make_entry(3, 2, 1, 0, 1, 0, 2, 0, 3));  // endless empty loop in state 2
    for (int i = 4; i < NUM_ENTRIES; i++)              // unreachable filler, extreme fields
      send_item(make_entry(i, 15, 1'(i % 2), 15, 1'(i % 2), 15, 15, 1'(i % 2), 15));
    drain();
    write_reg(CFG_TABLE_ENTRIES, NUM_ENTRIES);
    write_reg(CFG_START_STATE, 0);
    write_reg(CFG_FINAL_STATE_A, 1);
    write_reg(CFG_FINAL_STATE_B, 15);
    write_reg(CFG_BOTTOM_REQUIRED, 1);
    write_reg(CFG_BOTTOM_SYMBOL, 15);
    // accepted string, then an unbalanced one, then a stuck one
    send_item(make_cmd(CMD_BEGIN, 0));
    send_item(make_cmd(CMD_SYMBOL, 0));
    send_item(make_cmd(CMD_SYMBOL, 1));
    send_item(make_cmd(CMD_END, 0));
    send_item(make_cmd(CMD_SYMBOL, 0));   // after end nothing resets
    send_item(make_cmd(CMD_END, 0));
    send_item(make_cmd(CMD_BEGIN, 0));
    send_item(make_cmd(CMD_SYMBOL, 1));   // close on bare marker: stuck
    send_item(make_cmd(CMD_SYMBOL, 15));  // stays stuck
    send_item(make_cmd(CMD_END, 0));
    drain();
    // empty-move loop hits the chain cap; pop on an empty stack never fits
    write_reg(CFG_START_STATE, 2);
    send_item(make_cmd(CMD_BEGIN, 0));
    send_item(make_cmd(CMD_SYMBOL, 0));
    send_item(make_cmd(CMD_BEGIN, 0));
    send_item(make_cmd(CMD_END, 0));
    drain();
    write_reg(CFG_START_STATE, 1);
    write_reg(CFG_BOTTOM_REQUIRED, 0);
    send_item(make_cmd(CMD_BEGIN, 0));
    send_item(make_cmd(CMD_END, 0));      // empty stack accepted
    send_item(make_cmd(CMD_SYMBOL, 1));   // pop from empty stack: stuck
    send_item(make_cmd(CMD_END, 0));
    drain();
  endtask

  // keep opening until the stack is full and a push is dropped
  task automatic test_stack_overflow();
    write_reg(CFG_START_STATE, 0);
    write_reg(CFG_BOTTOM_REQUIRED, 1);
    send_item(make_cmd(CMD_BEGIN, 0));
    for (int i = 0; i < STACK_SLOTS + 1; i++) send_item(make_cmd(CMD_SYMBOL, 0));
    send_item(make_cmd(CMD_END, 0));
    drain();
    write_reg(CFG_TABLE_ENTRIES, 0);      // nothing searched: every symbol stuck
    send_item(make_cmd(CMD_BEGIN, 0));
    send_item(make_cmd(CMD_SYMBOL, 0));
    send_item(make_cmd(CMD_END, 0));
    drain();
  endtask

  // new random table and registers, written while idle
  task automatic load_random_setup();
    int te;
    drain();
    for (int i = 0; i < NUM_ENTRIES; i++) send_item(rand_entry(i));
    drain();
    case ($urandom_range(4))
      0:       te = 0;
      1:       te = NUM_ENTRIES;
      default: te = $urandom_range(NUM_ENTRIES);
    endcase
    write_reg(CFG_TABLE_ENTRIES, te);
    write_reg(CFG_START_STATE, $urandom_range(9) == 0 ? $urandom_range(15) : $urandom_range(3));
    write_reg(CFG_FINAL_STATE_A, $urandom_range(9) == 0 ? 15 : $urandom_range(3));
    write_reg(CFG_FINAL_STATE_B, $urandom_range(15));
    write_reg(CFG_BOTTOM_REQUIRED, $urandom_range(1));
    write_reg(CFG_BOTTOM_SYMBOL, $urandom_range(9) == 0 ? $urandom_range(15)
                                                        : $urandom_range(3));
  endtask

  // mostly whole strings with random content, some noise transactions
  task automatic test_random_strings(int budget, int s_pct, int r_pct);
    int stop_at, len;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(5) == 0) load_random_setup();
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0:       send_item(rand_entry($urandom_range(31)));
          1:       send_item(make_cmd(CMD_BEGIN, 4'($urandom)));
          2:       send_item(make_cmd(CMD_SYMBOL, 4'($urandom)));
          default: send_item(make_cmd(CMD_END, 4'($urandom)));
        endcase
      end else begin
        len = $urandom_range(19) == 0 ? $urandom_range(80, 40) : $urandom_range(12);
        send_item(make_cmd(CMD_BEGIN, 4'($urandom)));
        for (int i = 0; i < len; i++)
          send_item(make_cmd(CMD_SYMBOL, $urandom_range(9) == 0 ? 4'($urandom)
                                                                : 4'($urandom_range(3))));
        if ($urandom_range(7) != 0) send_item(make_cmd(CMD_END, 4'($urandom)));
      end
    end
  endtask

  // --- sequence ----------------------------------------------------------

  initial begin
    errors = 0; cycles = 0; items_sent = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    // mirror of the reset state
    sp = 0; cur_state = 4'd0; stuck = 1'b0;
    n_entries = 0; start_st = 4'd0; final_a = 4'd0; final_b = 4'd0;
    need_bottom = 1'b1; bottom_sym = 4'd0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_bus.valid = 1'b0; in_bus.command = CMD_WRITE; in_bus.entry_index = '0;
    in_bus.from_state = '0; in_bus.read_is_empty = 1'b0; in_bus.read_symbol = '0;
    in_bus.pop_is_empty = 1'b0; in_bus.pop_symbol = '0; in_bus.to_state = '0;
    in_bus.push_is_empty = 1'b0; in_bus.push_symbol = '0; in_bus.input_symbol = '0;
    out_bus.ready = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_brackets();
    test_stack_overflow();
    test_random_strings(510, 34, 57);
    test_random_strings(510, 57, 34);
    test_random_strings(510, 0, 0);

    drain();
    repeat (40) @(negedge clk_i);
    if (errors == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
